// ----- sv/fbsc_pkg.sv -----
`timescale 1ns / 1ps

package fbsc_pkg;

    localparam int ROUND_COUNT_DEF = 16;
    localparam int HALF_W          = 16;
    localparam int BLOCK_W         = 32;
    localparam int KEY_W           = 16;
    localparam int ROW_COUNT       = 16;

    // one bit per column of {L,key}: bit k selects word bit k
    localparam logic [BLOCK_W-1:0] SEL_ROWS [ROW_COUNT] = '{
        32'b1101_0101_0101_1001_1001_0100_0010_0111,
        32'b1110_0010_0101_0010_1111_1110_0001_0100,
        32'b1001_1101_1011_1000_0010_1100_0111_0001,
        32'b1101_1001_0000_1101_1101_0101_0101_1000,
        32'b0100_1000_1111_1011_0110_0110_1100_0010,
        32'b1001_1001_0101_0001_1111_1010_0001_0101,
        32'b0101_0110_1010_1100_1011_0110_0110_0010,
        32'b0110_0000_0101_1111_1010_0011_0101_0101,
        32'b0110_0110_1011_0001_1110_0010_1100_1010,
        32'b0001_0010_1111_0100_0110_1110_1110_1000,
        32'b1101_0010_1010_0011_1011_1011_0100_0010,
        32'b1000_0000_1111_1010_0011_0111_1100_0101,
        32'b1101_0101_0111_0001_1001_1000_1010_0110,
        32'b1000_0110_1111_0100_0100_1100_1011_0110,
        32'b0010_0010_1001_1000_0101_1111_0110_1101,
        32'b0101_1000_0110_1101_0010_1110_1110_0010
    };

    // output bit 15-i takes gathered bit PERM_COL[i]
    localparam logic [3:0] PERM_COL [HALF_W] = '{
        4'd5, 4'd9, 4'd12, 4'd7, 4'd15, 4'd10, 4'd2, 4'd13,
        4'd1, 4'd14, 4'd3, 4'd0, 4'd8, 4'd4, 4'd11, 4'd6
    };

    typedef struct packed {
        logic              valid;
        logic [HALF_W-1:0] left;
        logic [HALF_W-1:0] right;
        logic [KEY_W-1:0]  key;
    } t_stage;

    // round function: gather marked bits msb first, then permute
    function automatic logic [HALF_W-1:0] mix_half(
        input logic [HALF_W-1:0] half,
        input logic [KEY_W-1:0]  key,
        input logic [3:0]        row
    );
        logic [BLOCK_W-1:0] word;
        logic [BLOCK_W-1:0] mask;
        logic [HALF_W-1:0]  gathered;
        logic [HALF_W-1:0]  permuted;
        word     = {half, key};
        mask     = SEL_ROWS[row];
        gathered = '0;
        for (int k = BLOCK_W - 1; k >= 0; k--) begin
            if (mask[k]) begin
                gathered = {gathered[HALF_W-2:0], word[k]};
            end
        end
        for (int i = 0; i < HALF_W; i++) begin
            permuted[HALF_W-1-i] = gathered[PERM_COL[i]];
        end
        return permuted;
    endfunction

endpackage

// ----- sv/fbsc_round.sv -----
`timescale 1ns / 1ps

module fbsc_round
    import fbsc_pkg::*;
#(
    parameter int ROUND_INDEX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    output t_stage o_stage
);

    localparam logic [3:0] ROW = 4'(ROUND_INDEX % ROW_COUNT);

    t_stage n_stage;
    t_stage r_stage;

    // one feistel round: swap halves, xor the mixed left into right
    always_comb begin
        n_stage.valid = i_stage.valid;
        n_stage.key   = i_stage.key;
        n_stage.left  = i_stage.right;
        n_stage.right = mix_half(i_stage.left, i_stage.key, ROW) ^ i_stage.right;
    end

    // stage register: valid bit under reset, payload without reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.left  <= n_stage.left;
        r_stage.right <= n_stage.right;
        r_stage.key   <= n_stage.key;
    end

    assign o_stage = r_stage;

endmodule

// ----- sv/feistel_bit_select_cipher_32_core.sv -----
`timescale 1ns / 1ps

// 32-bit feistel bit-select cipher, fully pipelined.
// input channel: raise i_start with i_plain_block and i_cipher_key; the item
// is taken at the rising edge where i_start is high and o_busy is low.
// o_busy is never raised, so an item may be started in every cycle.
// result channel: o_cipher_block is valid for exactly one cycle while
// o_done is high; the receiver cannot hold it off.
// pipeline: one register stage per round, ROUND_COUNT stages (16 by default),
// between the accepting edge and the edge that takes the result.
// throughput: one item per cycle; every round is fixed wiring plus an xor.
// reset: synchronous, active low; clears the stage valid bits so no stale
// item comes out, items in flight are dropped.
// results are in order of acceptance with no gaps.
module feistel_bit_select_cipher_32_core
    import fbsc_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [BLOCK_W-1:0] i_plain_block,
    input  logic [KEY_W-1:0]   i_cipher_key,
    output logic               o_done,
    output logic [BLOCK_W-1:0] o_cipher_block
);

    t_stage s_stage [ROUND_COUNT+1];

    // pipeline never stalls
    assign o_busy = 1'b0;

    // stage input from the command ports
    always_comb begin
        s_stage[0].valid = i_start && !o_busy;
        s_stage[0].left  = i_plain_block[BLOCK_W-1:HALF_W];
        s_stage[0].right = i_plain_block[HALF_W-1:0];
        s_stage[0].key   = i_cipher_key;
    end

    // one registered round per stage
    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        fbsc_round #(
            .ROUND_INDEX(g)
        ) u_round (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_stage(s_stage[g]),
            .o_stage(s_stage[g+1])
        );
    end

    // result strobe and block
    assign o_done         = s_stage[ROUND_COUNT].valid;
    assign o_cipher_block = {s_stage[ROUND_COUNT].left, s_stage[ROUND_COUNT].right};

    // a result strobe always comes from an item that was started
    a_done_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, ROUND_COUNT))
        else $error("result strobe without matching start");

    // the key travels with its item through every stage
    a_key_carried: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (s_stage[ROUND_COUNT].key == $past(i_cipher_key, ROUND_COUNT)))
        else $error("key lost alignment with its item");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

endmodule

// ----- test/feistel_bit_select_cipher_32_core_test.sv -----
`timescale 1ns / 1ps

module feistel_bit_select_cipher_32_core_test;
    import fbsc_pkg::*;

    localparam int ROUNDS      = 16;
    localparam int RANDOM_ITEMS = 1300;

    // selection rows, bit 31 is the msb of {L,key}
    localparam logic [31:0] SELECT_ROWS [16] = '{
        32'hD5599427, 32'hE252FE14, 32'h9DB82C71, 32'hD90DD558,
        32'h48FB66C2, 32'h9951FA15, 32'h56ACB662, 32'h605FA355,
        32'h66B1E2CA, 32'h12F46EE8, 32'hD2A3BB42, 32'h80FA37C5,
        32'hD57198A6, 32'h86F44CB6, 32'h22985F6D, 32'h586D2EE2
    };

    // output bit 15-i takes gathered bit PERMUTE_SRC[i]
    localparam int PERMUTE_SRC [16] = '{
        5, 9, 12, 7, 15, 10, 2, 13, 1, 14, 3, 0, 8, 4, 11, 6
    };

    typedef struct packed {
        logic [BLOCK_W-1:0] block;
        logic [KEY_W-1:0]   key;
        logic               drain;
    } t_plain_item;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic [BLOCK_W-1:0] i_plain_block = '0;
    logic [KEY_W-1:0]   i_cipher_key = '0;
    logic               o_busy;
    logic               o_done;
    logic [BLOCK_W-1:0] o_cipher_block;

    t_plain_item        plain_items[$];
    logic [BLOCK_W-1:0] pending_ciphers[$];
    int                 n_accepted = 0;
    int                 n_raised = 0;
    int                 mismatches = 0;
    int                 burst_left = 0;
    int                 gap_left = 0;

    feistel_bit_select_cipher_32_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_plain_block  (i_plain_block),
        .i_cipher_key   (i_cipher_key),
        .o_done         (o_done),
        .o_cipher_block (o_cipher_block)
    );

    // one round: gather marked bits msb first, then permute
    function automatic logic [15:0] round_mix(
        input logic [15:0] half,
        input logic [15:0] key,
        input int          rnd
    );
        logic [31:0] word;
        logic [31:0] sel;
        logic [15:0] gath;
        logic [15:0] perm;
        word = {half, key};
        sel  = SELECT_ROWS[rnd % 16];
        gath = '0;
        for (int c = 0; c < 32; c++) begin
            if (sel[31-c]) begin
                gath = (gath << 1) | 16'(word[31-c]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            perm[15-i] = gath[PERMUTE_SRC[i]];
        end
        return perm;
    endfunction

    // full encryption of one block
    function automatic logic [31:0] encrypt_block(
        input logic [31:0] blk,
        input logic [15:0] key
    );
        logic [15:0] lft;
        logic [15:0] rgt;
        logic [15:0] nxt;
        lft = blk[31:16];
        rgt = blk[15:0];
        for (int r = 0; r < ROUNDS; r++) begin
            nxt = round_mix(lft, key, r) ^ rgt;
            lft = rgt;
            rgt = nxt;
        end
        return {lft, rgt};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic add_item(input logic [31:0] blk, input logic [15:0] key, input logic drain);
        t_plain_item it;
        it.block = blk;
        it.key   = key;
        it.drain = drain;
        plain_items.push_back(it);
    endtask

    // random item with a mix of value shapes
    task automatic add_random_item(input logic drain);
        logic [31:0] blk;
        logic [15:0] key;
        case ($urandom_range(0, 5))
            0: begin
                blk = $urandom & $urandom & $urandom;
                key = 16'($urandom & $urandom & $urandom);
            end
            1: begin
                blk = $urandom | $urandom | $urandom;
                key = 16'($urandom | $urandom | $urandom);
            end
            2: begin
                blk = 32'h1 << $urandom_range(0, 31);
                key = 16'h1 << $urandom_range(0, 15);
            end
            3: begin
                blk = $urandom;
                key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            default: begin
                blk = $urandom;
                key = 16'($urandom);
            end
        endcase
        add_item(blk, key, drain);
    endtask

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("feistel_bit_select_cipher_32_core_test: errors");
        $finish;
    end

    // driver: bursts of items with random gaps, optional drain pause
    always @(negedge i_clk) begin
        logic nxt_start;
        t_plain_item it;
        if (i_rst_n && n_accepted == n_raised) begin
            nxt_start = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (plain_items.size() != 0 &&
                         !(plain_items[0].drain && pending_ciphers.size() != 0)) begin
                it = plain_items.pop_front();
                i_plain_block <= it.block;
                i_cipher_key  <= it.key;
                nxt_start = 1'b1;
                n_raised++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    if (n_raised >= 300 && n_raised < 600) begin
                        gap_left = 0;
                    end else if ($urandom_range(0, 3) == 0) begin
                        gap_left = $urandom_range(5, 20);
                    end else begin
                        gap_left = $urandom_range(0, 3);
                    end
                end
            end
            i_start <= nxt_start;
        end
    end

    // monitor: record accepted items, check each result strobe
    always @(posedge i_clk) begin
        logic [BLOCK_W-1:0] want;
        if (i_rst_n) begin
            if (i_start && o_busy === 1'b0) begin
                pending_ciphers.push_back(encrypt_block(i_plain_block, i_cipher_key));
                n_accepted++;
            end
            if (o_done !== 1'b0) begin
                if (o_done !== 1'b1) begin
                    report_mismatch("o_done is unknown");
                end else if (pending_ciphers.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", o_cipher_block));
                end else begin
                    want = pending_ciphers.pop_front();
                    if (o_cipher_block !== want) begin
                        report_mismatch($sformatf("cipher_block got %h want %h",
                                                  o_cipher_block, want));
                    end
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        // extremes and simple patterns
        add_item(32'h0000_0000, 16'h0000, 1'b0);
        add_item(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_item(32'hFFFF_FFFF, 16'h0000, 1'b0);
        add_item(32'h0000_0000, 16'hFFFF, 1'b0);
        add_item(32'hFFFF_0000, 16'h0000, 1'b0);
        add_item(32'h0000_FFFF, 16'h0000, 1'b0);
        add_item(32'hFFFF_0000, 16'hFFFF, 1'b0);
        add_item(32'h0000_FFFF, 16'hFFFF, 1'b0);
        add_item(32'hAAAA_AAAA, 16'h5555, 1'b0);
        add_item(32'h5555_5555, 16'hAAAA, 1'b0);
        add_item(32'h8000_0000, 16'h0001, 1'b0);
        add_item(32'h0000_0001, 16'h8000, 1'b0);
        add_item(32'h0001_8000, 16'h0000, 1'b0);
        add_item(32'h7FFF_FFFF, 16'h7FFF, 1'b0);
        add_item(32'hFFFF_FFFE, 16'hFFFE, 1'b0);
        add_item(32'h1234_5678, 16'h9ABC, 1'b0);
        add_item(32'hDEAD_BEEF, 16'hCAFE, 1'b0);
        add_item(32'h0F0F_F0F0, 16'h00FF, 1'b0);
        add_item(32'hF0F0_0F0F, 16'hFF00, 1'b0);
        add_item(32'h0000_0000, 16'h0000, 1'b0);

        // random part, pausing for a full drain at the start and midway
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            add_random_item(n == 0 || n == RANDOM_ITEMS / 2);
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (plain_items.size() != 0 || n_accepted != n_raised ||
               pending_ciphers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (ROUND_COUNT_DEF + 8) @(posedge i_clk);

        if (pending_ciphers.size() != 0) begin
            report_mismatch($sformatf("%0d results never came", pending_ciphers.size()));
        end
        if (mismatches == 0) begin
            $display("feistel_bit_select_cipher_32_core_test: clean");
        end else begin
            $display("feistel_bit_select_cipher_32_core_test: errors");
        end
        $finish;
    end

endmodule
